>>> sv/b64sd_pkg.sv
// shared types, constants and the character map of the base64 stream decoder
package b64sd_pkg;

	localparam int unsigned GROUP_FIFO_DEPTH = 4;
	localparam int unsigned GROUP_BYTES      = 3;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [5:0] SEXTET_LOWER_BASE = 6'h1A;
	localparam logic [5:0] SEXTET_DIGIT_BASE = 6'h34;
	localparam logic [5:0] SEXTET_PLUS       = 6'h3E;
	localparam logic [5:0] SEXTET_SLASH      = 6'h3F;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} b64sd_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
		logic       decode_error;
	} b64sd_out_t;

	// up to three decoded bytes released by one character, plus end marks
	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic [1:0]                  count;
		logic                        msg_end;
		logic                        err;
	} b64sd_group_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} b64sd_sextet_t;

	function automatic b64sd_sextet_t map_char(input logic [7:0] c);
		b64sd_sextet_t s;
		s.ok    = 1'b1;
		s.value = 6'd0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			s.value = 6'(c - CHAR_UPPER_A);
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
		end else if (c == CHAR_PLUS) begin
			s.value = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			s.value = SEXTET_SLASH;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

>>> sv/b64sd_front.sv
// front end: accepts characters, maps them to sextets and forms byte groups
module b64sd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64sd_pkg::b64sd_in_t    char_item,
	input  logic                    fifo_full,
	output logic                    grp_push,
	output b64sd_pkg::b64sd_group_t grp
);
	import b64sd_pkg::*;

	logic [17:0]   accum_q, accum_n;
	logic [1:0]    held_q, held_n;
	logic          pad_q, pad_n;
	logic          err_q, err_n;
	logic          accept;
	b64sd_sextet_t sx;
	logic [23:0]   word;

	assign accept = push && !fifo_full;
	assign sx     = map_char(char_item.char_in);
	assign word   = {accum_q, sx.value};

	always_comb begin
		accum_n = accum_q;
		held_n  = held_q;
		pad_n   = pad_q;
		err_n   = err_q;
		grp     = '0;
		if (accept) begin
			if (!pad_q && !err_q) begin
				if (char_item.char_in == CHAR_PAD) begin
					pad_n = 1'b1;
				end else if (!sx.ok) begin
					err_n = 1'b1;
				end else if (held_q == 2'd3) begin
					grp.bytes[0] = word[23:16];
					grp.bytes[1] = word[15:8];
					grp.bytes[2] = word[7:0];
					grp.count    = 2'd3;
					accum_n      = '0;
					held_n       = '0;
				end else begin
					accum_n = {accum_q[11:0], sx.value};
					held_n  = held_q + 2'd1;
				end
			end
			if (char_item.last_char) begin
				// flush of leftover characters, nothing on an error
				if (!err_n) begin
					case (held_n)
						2'd2: begin
							grp.bytes[0] = accum_n[11:4];
							grp.count    = 2'd1;
						end
						2'd3: begin
							grp.bytes[0] = accum_n[17:10];
							grp.bytes[1] = accum_n[9:2];
							grp.count    = 2'd2;
						end
						default: ;
					endcase
				end
				grp.msg_end = 1'b1;
				grp.err     = err_n;
				accum_n     = '0;
				held_n      = '0;
				pad_n       = 1'b0;
				err_n       = 1'b0;
			end
		end
	end

	assign grp_push = accept && ((grp.count != 2'd0) || char_item.last_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			held_q  <= '0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			accum_q <= accum_n;
			held_q  <= held_n;
			pad_q   <= pad_n;
			err_q   <= err_n;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && char_item.last_char |=> held_q == 2'd0 && !pad_q && !err_q)
		else $error("state not cleared after last character");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		grp_push |-> !fifo_full)
		else $error("group pushed into full queue");

	a_flush_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		grp_push && grp.err |-> grp.msg_end && grp.count == 2'd0)
		else $error("bytes released on an errored message end");

endmodule

>>> sv/b64sd_fifo.sv
// short register queue of byte groups between front and back
module b64sd_fifo #(
	parameter int unsigned DEPTH = b64sd_pkg::GROUP_FIFO_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64sd_pkg::b64sd_group_t wr_data,
	output logic                    full,
	input  logic                    pop,
	output b64sd_pkg::b64sd_group_t rd_data,
	output logic                    empty
);
	import b64sd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	b64sd_group_t  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count overrun");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count missed a push");

endmodule

>>> sv/b64sd_back.sv
// back end: takes byte groups from the queue and hands out one result per transfer
module b64sd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fifo_empty,
	input  b64sd_pkg::b64sd_group_t fifo_data,
	output logic                    fifo_pop,
	input  logic                    pop,
	output logic                    empty,
	output b64sd_pkg::b64sd_out_t   result
);
	import b64sd_pkg::*;

	b64sd_group_t grp_q;
	logic         grp_v_q;
	logic [1:0]   idx_q;
	b64sd_out_t   out_q;
	logic         out_v_q;

	logic         load;
	logic         grp_done;
	logic [1:0]   last_idx;
	b64sd_out_t   next_out;

	// a group with no byte still gives one result carrying the end mark
	assign last_idx = (grp_q.count == 2'd0) ? 2'd0 : grp_q.count - 2'd1;
	assign load     = !out_v_q || pop;
	assign grp_done = grp_v_q && load && (idx_q == last_idx);
	assign fifo_pop = !fifo_empty && (!grp_v_q || grp_done);

	always_comb begin
		next_out = '0;
		if (grp_q.count != 2'd0) begin
			next_out.byte_valid = 1'b1;
			case (idx_q)
				2'd0:    next_out.data_byte = grp_q.bytes[0];
				2'd1:    next_out.data_byte = grp_q.bytes[1];
				default: next_out.data_byte = grp_q.bytes[2];
			endcase
		end
		if (idx_q == last_idx) begin
			next_out.message_end  = grp_q.msg_end;
			next_out.decode_error = grp_q.msg_end && grp_q.err;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			grp_q <= fifo_data;
		end
		if (load && grp_v_q) begin
			out_q <= next_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_v_q <= 1'b0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= grp_v_q;
			end
			if (fifo_pop) begin
				grp_v_q <= 1'b1;
				idx_q   <= '0;
			end else if (grp_done) begin
				grp_v_q <= 1'b0;
				idx_q   <= '0;
			end else if (grp_v_q && load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign empty  = !out_v_q;
	assign result = out_q;

	a_error_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.decode_error |-> result.message_end)
		else $error("error flag without message end");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.byte_valid |-> result.data_byte == 8'd0 && result.message_end)
		else $error("byteless result not a clean end mark");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		grp_v_q |-> idx_q <= last_idx)
		else $error("byte index past group");

endmodule

>>> sv/base64_stream_decoder.sv
// top level of the streaming base64 decoder
//
// usage
//   input channel: one character per transfer (push / full), with last_char
//   marking the final character of a message; a transfer happens when push is
//   high and full is low
//   result channel: one decoded byte per transfer (empty / pop); the oldest
//   result sits on the result port while empty is low and leaves on pop
//   every fourth alphabet character yields three results, the last character
//   flushes one or two leftover bytes; the final result of a message carries
//   message_end and decode_error; after an error no more bytes are released
//   a last character that releases no byte yields one result with byte_valid low
// timing
//   one character per cycle is accepted unless full is high; its results are
//   registered in group and output registers; the back end gives one byte per
//   cycle while pop is high; a FIFO_DEPTH-entry queue absorbs three-byte bursts
// reset and stall
//   arst_n clears decoder state, queue count and output valid flag at once
//   when the receiver stops popping, the output register holds, the queue
//   fills and full rises; no character or result is ever dropped
module base64_stream_decoder #(
	parameter int unsigned FIFO_DEPTH = b64sd_pkg::GROUP_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  b64sd_pkg::b64sd_in_t  char_item,
	output logic                  empty,
	input  logic                  pop,
	output b64sd_pkg::b64sd_out_t result
);
	import b64sd_pkg::*;

	// groups handed from the classifying front end to the queue
	logic         grp_push;
	b64sd_group_t grp_wr;

	// queue head seen by the back end
	logic         q_pop;
	logic         q_empty;
	b64sd_group_t grp_rd;

	b64sd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_item (char_item),
		.fifo_full (full),
		.grp_push  (grp_push),
		.grp       (grp_wr)
	);

	b64sd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (grp_push),
		.wr_data (grp_wr),
		.full    (full),
		.pop     (q_pop),
		.rd_data (grp_rd),
		.empty   (q_empty)
	);

	// back end serializes each group into single-byte transfers
	b64sd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (q_empty),
		.fifo_data  (grp_rd),
		.fifo_pop   (q_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule

>>> verif/tb.sv
// self-checking testbench of the base64 stream decoder
module tb;
	import b64sd_pkg::*;

	// no-transfer watchdog and drain time after the last result
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	b64sd_in_t  char_item = '0;
	logic       full;
	logic       empty;
	b64sd_out_t result;

	base64_stream_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_item(char_item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder state as the predictor sees it
	logic [17:0] acc_bits = '0;
	logic [1:0]  acc_count = '0;
	logic        pad_hit = 1'b0;
	logic        bad_hit = 1'b0;

	// decoded bytes still to come out of the block, oldest first
	b64sd_out_t pending_bytes[$];

	// idle odds in percent for each side
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// run statistics
	int unsigned items_sent = 0;
	int unsigned live_chars = 0;
	int unsigned messages_sent = 0;
	int unsigned flagged_messages = 0;
	int unsigned bytes_checked = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;

	// standard alphabet lookup, returns 0 for anything outside it
	function automatic logic char_to_sextet(input logic [7:0] c, output logic [5:0] v);
		v = '0;
		char_to_sextet = 1'b1;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			v = 6'(c - CHAR_UPPER_A);
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			v = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			v = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
		end else if (c == CHAR_PLUS) begin
			v = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			v = SEXTET_SLASH;
		end else begin
			char_to_sextet = 1'b0;
		end
	endfunction

	// encoder side of the alphabet, used to build well-formed text
	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		if (v < SEXTET_LOWER_BASE) begin
			return CHAR_UPPER_A + 8'(v);
		end else if (v < SEXTET_DIGIT_BASE) begin
			return CHAR_LOWER_A + 8'(v - SEXTET_LOWER_BASE);
		end else if (v < SEXTET_PLUS) begin
			return CHAR_DIGIT_0 + 8'(v - SEXTET_DIGIT_BASE);
		end else if (v == SEXTET_PLUS) begin
			return CHAR_PLUS;
		end
		return CHAR_SLASH;
	endfunction

	function automatic b64sd_out_t byte_result(input logic [7:0] b);
		b64sd_out_t r;
		r.data_byte    = b;
		r.byte_valid   = 1'b1;
		r.message_end  = 1'b0;
		r.decode_error = 1'b0;
		return r;
	endfunction

	// advance the predicted state by one character and queue the bytes it releases
	// returns 1 when the character was not skipped after padding or an error
	function automatic logic decode_char(input b64sd_in_t it);
		b64sd_out_t  outs[3];
		int          n;
		logic        live;
		logic        ok;
		logic [5:0]  v;
		logic [23:0] word;
		n = 0;
		live = !pad_hit && !bad_hit;
		if (live) begin
			ok = char_to_sextet(it.char_in, v);
			if (it.char_in == CHAR_PAD) begin
				pad_hit = 1'b1;
			end else if (!ok) begin
				bad_hit = 1'b1;
			end else if (acc_count == 2'd3) begin
				// fourth character completes a group of three bytes
				word = {acc_bits, v};
				outs[0] = byte_result(word[23:16]);
				outs[1] = byte_result(word[15:8]);
				outs[2] = byte_result(word[7:0]);
				n = 3;
				acc_bits = '0;
				acc_count = '0;
			end else begin
				acc_bits = {acc_bits[11:0], v};
				acc_count = acc_count + 2'd1;
			end
		end
		if (it.last_char) begin
			// flush leftover characters unless the message is already bad
			if (!bad_hit) begin
				if (acc_count == 2'd2) begin
					outs[n] = byte_result(acc_bits[11:4]);
					n++;
				end else if (acc_count == 2'd3) begin
					outs[n] = byte_result(acc_bits[17:10]);
					outs[n + 1] = byte_result(acc_bits[9:2]);
					n += 2;
				end
			end
			if (n == 0) begin
				outs[0] = '0;
				n = 1;
			end
			outs[n - 1].message_end = 1'b1;
			outs[n - 1].decode_error = bad_hit;
			messages_sent++;
			if (bad_hit) begin
				flagged_messages++;
			end
			acc_bits = '0;
			acc_count = '0;
			pad_hit = 1'b0;
			bad_hit = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			pending_bytes = {pending_bytes, outs[i]};
		end
		return live;
	endfunction

	// one character transfer, with a random gap in front of it
	task automatic send_char(input logic [7:0] c, input logic last);
		b64sd_in_t it;
		it.char_in = c;
		it.last_char = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		items_sent++;
		if (decode_char(it)) begin
			live_chars++;
		end
	endtask

	// text as a sequence of characters, last mark on the final one if asked
	task automatic send_text(input string s, input logic ends);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], ends && (i == s.len() - 1));
		end
	endtask

	// sender holds off until the block has handed out everything predicted
	task automatic wait_for_results();
		push <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_alphabet_char();
		return sextet_to_char(6'($urandom_range(0, 63)));
	endfunction

	// any byte that is neither in the alphabet nor padding
	function automatic logic [7:0] random_bad_char();
		logic [7:0] c;
		logic [5:0] v;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (char_to_sextet(c, v) || c == CHAR_PAD);
		return c;
	endfunction

	// whole groups: three bytes on every fourth character, nothing on the rest
	task automatic test_group_release();
		send_text("TWFu", 1'b1);
		send_text("/+9z", 1'b1);
	endtask

	// leftover of three, two and one characters at the end of a message
	task automatic test_leftover_flush();
		send_text("TWE", 1'b1);
		// low bits of the second character are dropped unchecked
		send_text("TR", 1'b1);
		// single leftover gives one empty result
		send_text("T", 1'b1);
	endtask

	// padding ends decoding, later characters are skipped even if invalid
	task automatic test_padding();
		send_text("TQ==", 1'b1);
		send_text("TW=@", 1'b1);
	endtask

	// invalid characters at both ends of the byte range set the sticky error
	task automatic test_invalid_chars();
		send_text("T", 1'b0);
		send_char(8'h00, 1'b0);
		send_text("Q", 1'b1);
		send_text("/+", 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	// mostly well-formed messages with random content, some broken, some noise
	task automatic test_random_stream(input int unsigned target);
		int unsigned first;
		int unsigned kind;
		int unsigned groups;
		int unsigned tail;
		int unsigned len;
		int unsigned bad_pos;
		logic        padded;
		logic [7:0]  c;
		first = items_sent;
		while (items_sent - first < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10)
					: $urandom_range(0, 3);
				tail = $urandom_range(0, 3);
				if (groups == 0 && tail == 0) begin
					tail = 1;
				end
				padded = (tail >= 2) && $urandom_range(0, 1);
				len = groups * 4 + tail;
				for (int k = 0; k < len; k++) begin
					send_char(random_alphabet_char(), !padded && (k == len - 1));
				end
				for (int k = tail; padded && k < 4; k++) begin
					send_char(CHAR_PAD, k == 3);
				end
			end else if (kind < 85) begin
				// one bad spot: early padding or an invalid character
				len = $urandom_range(1, 10);
				bad_pos = $urandom_range(0, len - 1);
				for (int k = 0; k < len; k++) begin
					if (k != bad_pos) begin
						c = random_alphabet_char();
					end else if ($urandom_range(0, 1) != 0) begin
						c = CHAR_PAD;
					end else begin
						c = random_bad_char();
					end
					send_char(c, k == len - 1);
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send_char(8'($urandom_range(0, 255)), k == len - 1);
				end
			end
		end
	endtask

	// receiver pulls results at random
	always @(posedge clk) begin
		pop <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// compare every popped result with the oldest prediction
	always @(posedge clk) begin
		b64sd_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected result byte=%02h valid=%b end=%b err=%b", $time,
					result.data_byte, result.byte_valid, result.message_end,
					result.decode_error);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (result.data_byte !== want.data_byte
						|| result.byte_valid !== want.byte_valid
						|| result.message_end !== want.message_end
						|| result.decode_error !== want.decode_error) begin
					$display("%0t: mismatch, expected byte=%02h valid=%b end=%b err=%b",
						$time, want.data_byte, want.byte_valid, want.message_end,
						want.decode_error);
					$display("%0t:           actual   byte=%02h valid=%b end=%b err=%b",
						$time, result.data_byte, result.byte_valid, result.message_end,
						result.decode_error);
					mismatches++;
				end
				if (want.byte_valid) begin
					bytes_checked++;
				end
			end
		end
	end

	// end the run if no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("tb failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under light sender gaps and heavy receiver stalls
		send_idle_pct = 9;
		recv_idle_pct = 66;
		test_group_release();
		test_leftover_flush();
		test_padding();
		test_invalid_chars();

		// random part, pausing the sender until drained at each switch
		wait_for_results();
		test_random_stream(134);
		wait_for_results();
		send_idle_pct = 66;
		recv_idle_pct = 9;
		test_random_stream(134);
		wait_for_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_stream(134);

		// let the last results out, then watch for stray ones
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d messages (%0d flagged bad) in %0d characters, %0d decoded",
			messages_sent, flagged_messages, items_sent, live_chars);
		$display("checked %0d data bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

>>> base64_stream_decoder.f
sv/b64sd_pkg.sv
sv/b64sd_front.sv
sv/b64sd_fifo.sv
sv/b64sd_back.sv
sv/base64_stream_decoder.sv
verif/tb.sv
